// ===== hdl/lte_pkg.sv =====
// ----------------------------------------------------------------------------
// lte_pkg
// Shared widths, register indexes and the sigmoid table builder for the
// logistic treatment effect mean block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lte_pkg;

   // fixed by the payload: one lane per feature, one coefficient per lane
   localparam int FEATURE_COUNT = 4;

   localparam int SIGMOID_TABLE_DEPTH_DEF = 256;
   localparam int ROW_COUNT_WIDTH_DEF     = 16;

   localparam int DATA_W   = 16;
   localparam int PROD_W   = 2 * DATA_W;
   // sum of the lane products, the scaled intercept and the exposure term
   localparam int ETA_W    = PROD_W + $clog2(FEATURE_COUNT + 2) + 1;
   localparam int PROB_W   = 17;
   localparam int DIFF_W   = PROB_W + 1;
   localparam int MEAN_W   = 18;
   localparam int ROWS_W   = 16;
   localparam int Q_FRAC   = 16;
   localparam int OFF_W    = 20;

   localparam int CLAMP_LIMIT = 50;
   localparam int CLAMP_Q16   = CLAMP_LIMIT * 65536;
   localparam int ETA_OFFSET  = 8 * 65536;
   localparam int PROB_ONE    = 65536;

   // register map
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_INTERCEPT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_EXPOSURE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_A    = 3'd2;

   // shift-subtract division, used only while building constants
   function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // sigmoid at the middle of bin k, Q0.16
   function automatic logic [PROB_W-1:0] sig_entry(int k, int depth);
      logic        pos;
      logic [63:0] mag;
      logic [63:0] u;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] e;
      logic [63:0] den;
      logic [63:0] s;
      pos  = (2 * k + 1 >= depth);
      mag  = pos ? 64'(2 * k + 1 - depth) : 64'(depth - 2 * k - 1);
      u    = udiv64(mag << 32, 64'(depth));
      term = 64'h1_0000_0000;
      sum  = 64'h1_0000_0000;
      // exp(-u) by the alternating series
      for (int i = 1; i <= 16; i++) begin
         term = udiv64((term * u) >> 32, 64'(i));
         if (i % 2 == 1)
            sum = sum - term;
         else
            sum = sum + term;
      end
      e = sum;
      // three squarings turn exp(-u) into exp(-8u)
      for (int r = 0; r < 3; r++) begin
         if (e >= 64'h1_0000_0000)
            e = 64'h1_0000_0000;
         else
            e = (e * e + 64'h8000_0000) >> 32;
      end
      den = 64'h1_0000_0000 + e;
      s   = udiv64(64'h1_0000_0000_0000 + (den >> 1), den);
      if (!pos)
         s = 64'(PROB_ONE) - s;
      return PROB_W'(s);
   endfunction

endpackage

// ===== hdl/lte_lane.sv =====
// ----------------------------------------------------------------------------
// lte_lane
// One feature lane: coefficient times feature, registered, in Q16.16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lte_lane
   import lte_pkg::*;
(
   input  logic                     clock,
   input  logic signed [DATA_W-1:0] coef,
   input  logic signed [DATA_W-1:0] feature,
   output logic signed [PROD_W-1:0] product
);

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;

   assign product_in = coef * feature;
   assign product    = product_ff;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// ===== hdl/lte_sigmoid.sv =====
// ----------------------------------------------------------------------------
// lte_sigmoid
// Table sigmoid of a Q16.16 predictor, registered Q0.16 probability.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lte_sigmoid
   import lte_pkg::*;
#(
   parameter int DEPTH = SIGMOID_TABLE_DEPTH_DEF
)
(
   input  logic                    clock,
   input  logic signed [ETA_W-1:0] eta,
   output logic [PROB_W-1:0]       prob
);

   localparam int IDX_W   = $clog2(DEPTH);
   localparam int SCALE_W = OFF_W + IDX_W;
   localparam logic signed [ETA_W-1:0] CLAMP_ETA  = ETA_W'(CLAMP_Q16);
   localparam logic signed [ETA_W:0]   OFFSET_ETA = (ETA_W + 1)'(ETA_OFFSET);

   logic [PROB_W-1:0]       lut_w [DEPTH];
   logic signed [ETA_W:0]   off;
   logic [SCALE_W-1:0]      scaled;
   logic [IDX_W-1:0]        idx;
   logic [PROB_W-1:0]       prob_ff;
   logic [PROB_W-1:0]       prob_in;

   for (genvar k = 0; k < DEPTH; k++) begin : g_lut
      localparam logic [PROB_W-1:0] ENTRY = sig_entry(k, DEPTH);
      assign lut_w[k] = ENTRY;
   end

   always_comb begin
      off    = (ETA_W + 1)'(eta) + OFFSET_ETA;
      scaled = SCALE_W'(off[OFF_W-1:0]) * SCALE_W'(DEPTH);
      if (off < 0)
         idx = '0;
      else if (off[ETA_W:OFF_W] != '0)
         idx = IDX_W'(DEPTH - 1);
      else
         idx = scaled[OFF_W +: IDX_W];
      // above the clamp limit the probability is exactly one
      if (eta > CLAMP_ETA)
         prob_in = PROB_W'(PROB_ONE);
      else
         prob_in = lut_w[idx];
   end

   assign prob = prob_ff;

   always_ff @(posedge clock) begin
      prob_ff <= prob_in;
   end

endmodule

// ===== hdl/lte_divider.sv =====
// ----------------------------------------------------------------------------
// lte_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lte_divider #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] iter_ff, iter_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] div_ff, div_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      trial   = {1'b0, shifted} - {2'b00, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = CNT_W'(NUM_W);
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[DEN_W+1]) begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         iter_in = iter_ff - 1'b1;
         if (iter_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

endmodule

// ===== hdl/logistic_treatment_effect_mean.sv =====
// ----------------------------------------------------------------------------
// logistic_treatment_effect_mean
// Streaming mean of p(exposed) - p(unexposed) of a logistic model over rows.
// Rows are taken one per cycle; a last row ends intake until its result forms.
// The mean comes from a bit-serial divider that yields one quotient bit a cycle.
// Synchronous active-high reset clears config registers, row count, sum and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module logistic_treatment_effect_mean
   import lte_pkg::*;
#(
   parameter int SIGMOID_TABLE_DEPTH = SIGMOID_TABLE_DEPTH_DEF,
   parameter int ROW_COUNT_WIDTH     = ROW_COUNT_WIDTH_DEF
)
(
   input  logic                     clock,
   input  logic                     reset,
   // configuration writes
   input  logic                     csr_we,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [DATA_W-1:0]        csr_wdata,
   // row beats
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [DATA_W-1:0] req_feature_a,
   input  logic signed [DATA_W-1:0] req_feature_b,
   input  logic signed [DATA_W-1:0] req_feature_c,
   input  logic signed [DATA_W-1:0] req_feature_d,
   input  logic                     req_last_row,
   // result beats
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [MEAN_W-1:0] rsp_mean_effect,
   output logic [ROWS_W-1:0]        rsp_rows_used,
   output logic                     rsp_row_overflow
);

   // sum of up to 2^W-1 differences of magnitude at most one in Q0.16
   localparam int SUM_W = ROW_COUNT_WIDTH + Q_FRAC + 1;
   localparam int MAG_W = SUM_W - 1;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_DRAIN,
      ST_DIV
   } state_type;

   state_type                 state_ff, state_in;
   logic signed [DATA_W-1:0]  intercept_ff, intercept_in;
   logic signed [DATA_W-1:0]  exposure_ff, exposure_in;
   logic signed [DATA_W-1:0]  coef_ff [FEATURE_COUNT];
   logic signed [DATA_W-1:0]  coef_in [FEATURE_COUNT];
   logic [ROW_COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                      ovf_ff, ovf_in;
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s2_valid_ff, s2_valid_in;
   logic                      s3_valid_ff, s3_valid_in;
   logic signed [ETA_W-1:0]   eta0_ff, eta0_in;
   logic signed [ETA_W-1:0]   eta1_ff, eta1_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [MEAN_W-1:0]  rsp_mean_ff, rsp_mean_in;
   logic [ROWS_W-1:0]         rsp_rows_ff, rsp_rows_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic signed [DATA_W-1:0]  feature_w [FEATURE_COUNT];
   logic signed [PROD_W-1:0]  product_w [FEATURE_COUNT];
   logic [PROB_W-1:0]         p0_w;
   logic [PROB_W-1:0]         p1_w;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [SUM_W-1:0]   sum_abs;
   logic                      accept;
   logic                      pipe_empty;
   logic                      div_start;
   logic                      div_done;
   logic [MAG_W-1:0]          quotient;
   logic [MEAN_W-1:0]         q_short;

   assign feature_w[0] = req_feature_a;
   assign feature_w[1] = req_feature_b;
   assign feature_w[2] = req_feature_c;
   assign feature_w[3] = req_feature_d;

   // stage 1: one multiplier lane per feature
   for (genvar i = 0; i < FEATURE_COUNT; i++) begin : g_lane
      lte_lane u_lane (
         .clock   (clock),
         .coef    (coef_ff[i]),
         .feature (feature_w[i]),
         .product (product_w[i])
      );
   end

   // stage 3: sigmoid lookups for the unexposed and exposed predictors
   lte_sigmoid #(
      .DEPTH (SIGMOID_TABLE_DEPTH)
   ) u_sig0 (
      .clock (clock),
      .eta   (eta0_ff),
      .prob  (p0_w)
   );

   lte_sigmoid #(
      .DEPTH (SIGMOID_TABLE_DEPTH)
   ) u_sig1 (
      .clock (clock),
      .eta   (eta1_ff),
      .prob  (p1_w)
   );

   lte_divider #(
      .NUM_W (MAG_W),
      .DEN_W (ROW_COUNT_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_abs[MAG_W-1:0]),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   assign req_ready  = (state_ff == ST_RUN);
   assign accept     = req_valid && req_ready;
   assign pipe_empty = !s1_valid_ff && !s2_valid_ff && !s3_valid_ff;
   // the divider starts once every counted row has reached the sum and the last result is taken
   assign div_start  = (state_ff == ST_DRAIN) && pipe_empty && !rsp_valid_ff;
   assign diff       = $signed({1'b0, p1_w}) - $signed({1'b0, p0_w});
   assign sum_abs    = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;
   assign q_short    = quotient[MEAN_W-1:0];

   always_comb begin
      state_in     = state_ff;
      intercept_in = intercept_ff;
      exposure_in  = exposure_ff;
      coef_in      = coef_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mean_in  = rsp_mean_ff;
      rsp_rows_in  = rsp_rows_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // configuration writes; indexes past the coefficients are dropped
      if (csr_we) begin
         case (csr_index)
            REG_INTERCEPT: intercept_in = csr_wdata;
            REG_EXPOSURE:  exposure_in  = csr_wdata;
            default: begin
               for (int i = 0; i < FEATURE_COUNT; i++) begin
                  if (csr_index == CSR_INDEX_W'(int'(REG_COEF_A) + i))
                     coef_in[i] = csr_wdata;
               end
            end
         endcase
      end

      // stage 2: merge the lanes into both predictors, Q16.16
      eta0_in = ETA_W'(intercept_ff) <<< 8;
      for (int i = 0; i < FEATURE_COUNT; i++)
         eta0_in = eta0_in + ETA_W'(product_w[i]);
      eta1_in = eta0_in + (ETA_W'(exposure_ff) <<< 8);

      s2_valid_in = s1_valid_ff;
      s3_valid_in = s2_valid_ff;

      // stage 4: accumulate the probability difference
      if (s3_valid_ff)
         sum_in = sum_ff + SUM_W'(diff);

      // row count and overflow are settled at intake
      s1_valid_in = 1'b0;
      if (accept) begin
         if (cnt_ff == {ROW_COUNT_WIDTH{1'b1}}) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in      = cnt_ff + 1'b1;
            s1_valid_in = 1'b1;
         end
      end

      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_RUN: begin
            if (accept && req_last_row)
               state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (div_start)
               state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               // truncation toward zero: divide magnitudes, then restore sign
               if (cnt_ff == '0)
                  rsp_mean_in = '0;
               else if (sum_ff[SUM_W-1])
                  rsp_mean_in = -$signed(q_short);
               else
                  rsp_mean_in = $signed(q_short);
               rsp_rows_in  = ROWS_W'(cnt_ff);
               rsp_ovf_in   = ovf_ff;
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               cnt_in       = '0;
               ovf_in       = 1'b0;
               state_in     = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_effect  = rsp_mean_ff;
   assign rsp_rows_used    = rsp_rows_ff;
   assign rsp_row_overflow = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         intercept_ff <= '0;
         exposure_ff  <= '0;
         for (int i = 0; i < FEATURE_COUNT; i++)
            coef_ff[i] <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         sum_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         intercept_ff <= intercept_in;
         exposure_ff  <= exposure_in;
         coef_ff      <= coef_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload, no reset needed
      eta0_ff     <= eta0_in;
      eta1_ff     <= eta1_in;
      rsp_mean_ff <= rsp_mean_in;
      rsp_rows_ff <= rsp_rows_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

endmodule

// ===== hdl/lte_checker.sv =====
// ----------------------------------------------------------------------------
// lte_checker
// Port-level checks for the logistic treatment effect mean block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lte_checker
   import lte_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_last_row,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [MEAN_W-1:0] rsp_mean_effect
);

   // a last row closes intake until its result is formed
   a_last_closes_intake: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_row |=> !req_ready)
      else $error("intake open after last row beat");

   // a new result only follows a period with intake closed
   a_result_after_close: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared while intake was open");

   // a mean of probability differences stays within one
   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mean_effect >= -18'sd65536) && (rsp_mean_effect <= 18'sd65536))
      else $error("mean effect out of range");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_effect))
      else $error("stalled result beat changed");

endmodule

bind logistic_treatment_effect_mean lte_checker u_lte_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_last_row    (req_last_row),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_mean_effect (rsp_mean_effect)
);

// ===== bench/tb_logistic_treatment_effect_mean.sv =====
// ----------------------------------------------------------------------------
// tb_logistic_treatment_effect_mean
// Self-checking bench for the streaming logistic treatment effect mean. Rows
// go in over a valid/ready channel. A model of the sigmoid table, the running
// sum and the saturating row count predicts every mean not pinned by hand, and
// each result beat is compared field by field in arrival order. A short table
// of directed rows comes first. Random phases with varied idling and a long
// result hold-off follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_logistic_treatment_effect_mean
   import lte_pkg::*;
();

   // bench constants
   localparam int          LUT_DEPTH       = 256;
   localparam int          COUNT_W         = 16;
   localparam int unsigned ROW_FULL        = (1 << COUNT_W) - 1;
   localparam longint      CLAMP_ETA       = 50 * 65536;
   localparam longint      TABLE_SHIFT     = 8 * 65536;
   localparam longint      TABLE_SPAN      = 16 * 65536;
   localparam int          SETTLE_CYCLES   = 64;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          PHASE_ROWS      = 100;
   localparam int          MAX_REPORTS     = 10;
   localparam int unsigned CYCLE_LIMIT     = 1_000_000;

   localparam longint unsigned Q32_ONE = 64'h1_0000_0000;

   // register map beyond what the package names
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_B   = REG_COEF_A + 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_C   = REG_COEF_A + 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_COEF_D   = REG_COEF_A + 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef enum logic {DIR_CSR, DIR_ROW} dir_kind_type;

   // one row beat; feat[0] is feature a
   typedef struct packed {
      logic [FEATURE_COUNT-1:0][DATA_W-1:0] feat;
      logic                                 last;
   } row_type;

   // one result beat
   typedef struct packed {
      logic [MEAN_W-1:0] mean;
      logic [ROWS_W-1:0] rows;
      logic              ovf;
   } mean_result_type;

   typedef struct {
      dir_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  idx;
      logic [DATA_W-1:0]       data;
      row_type                 row;
      bit                      typed;
      mean_result_type         res;
   } dir_entry_type;

   // dut ports, all inputs known from time zero
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [DATA_W-1:0]        csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_feature_a = '0;
   logic signed [DATA_W-1:0] req_feature_b = '0;
   logic signed [DATA_W-1:0] req_feature_c = '0;
   logic signed [DATA_W-1:0] req_feature_d = '0;
   logic                     req_last_row = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [MEAN_W-1:0] rsp_mean_effect;
   logic [ROWS_W-1:0]        rsp_rows_used;
   logic                     rsp_row_overflow;

   // model of the block
   int unsigned              prob_lut [LUT_DEPTH];
   logic signed [DATA_W-1:0] cfg_intercept;
   logic signed [DATA_W-1:0] cfg_exposure;
   logic signed [DATA_W-1:0] cfg_coef [FEATURE_COUNT];
   longint                   effect_sum;
   int unsigned              rows_counted;
   bit                       rows_dropped;

   // means still owed by the block, oldest first
   mean_result_type          awaited_means [$];
   dir_entry_type            dir_table [$];

   int unsigned              send_idle_pct;
   int unsigned              recv_stall_pct;
   bit                       hold_off_req;
   int                       hold_off_left;
   int                       error_count;
   int unsigned              cycle_count = 0;

   logistic_treatment_effect_mean u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_feature_a    (req_feature_a),
      .req_feature_b    (req_feature_b),
      .req_feature_c    (req_feature_c),
      .req_feature_d    (req_feature_d),
      .req_last_row     (req_last_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_mean_effect  (rsp_mean_effect),
      .rsp_rows_used    (rsp_rows_used),
      .rsp_row_overflow (rsp_row_overflow)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_logistic_treatment_effect_mean: FAIL");
         $finish;
      end
   end

   // sigmoid at the middle of each bin, Q0.16, pure integer math
   function automatic void build_logistic_lut();
      longint          num;
      longint unsigned mag;
      longint unsigned u;
      longint unsigned term;
      longint unsigned e;
      longint unsigned den;
      longint unsigned s;
      longint          series;
      for (int k = 0; k < LUT_DEPTH; k++) begin
         num    = 2 * k + 1 - LUT_DEPTH;
         mag    = (num < 0) ? -num : num;
         u      = (mag << 32) / LUT_DEPTH;
         // exp(-u) by alternating taylor terms up to degree 16
         term   = Q32_ONE;
         series = Q32_ONE;
         for (int i = 1; i <= 16; i++) begin
            term = ((term * u) >> 32) / i;
            if (i % 2 == 1)
               series = series - longint'(term);
            else
               series = series + longint'(term);
         end
         e = series;
         // three squarings take exp(-u) to exp(-8u)
         for (int r = 0; r < 3; r++)
            e = (e >= Q32_ONE) ? Q32_ONE : ((e * e + (Q32_ONE >> 1)) >> 32);
         den = Q32_ONE + e;
         s   = ((64'h1 << 48) + den / 2) / den;
         prob_lut[k] = 32'((num >= 0) ? s : 65536 - s);
      end
   endfunction

   // eta in Q16.16 to probability in Q0.16
   function automatic longint logistic_lookup(longint eta);
      longint shifted;
      int     bin;
      if (eta > CLAMP_ETA)
         return 65536;
      shifted = eta + TABLE_SHIFT;
      if (shifted < 0)
         bin = 0;
      else if (shifted >= TABLE_SPAN)
         bin = LUT_DEPTH - 1;
      else
         bin = int'((shifted * LUT_DEPTH) >>> 20);
      return longint'(prob_lut[bin]);
   endfunction

   function automatic void apply_register(logic [CSR_INDEX_W-1:0] idx,
                                          logic [DATA_W-1:0] data);
      case (idx)
         REG_INTERCEPT: cfg_intercept = data;
         REG_EXPOSURE:  cfg_exposure  = data;
         REG_COEF_A:    cfg_coef[0]   = data;
         REG_COEF_B:    cfg_coef[1]   = data;
         REG_COEF_C:    cfg_coef[2]   = data;
         REG_COEF_D:    cfg_coef[3]   = data;
         default: ;  // spare indexes write nothing
      endcase
   endfunction

   // add one row to the running effect unless the count is full; a last row closes the set
   function automatic void fold_row(input row_type row, output bit closes,
                                    output mean_result_type res);
      longint eta0;
      longint mean;
      if (rows_counted >= ROW_FULL) begin
         rows_dropped = 1'b1;
      end else begin
         eta0 = longint'(cfg_intercept) * 256;
         for (int i = 0; i < FEATURE_COUNT; i++)
            eta0 += longint'(cfg_coef[i]) * longint'($signed(row.feat[i]));
         effect_sum += logistic_lookup(eta0 + longint'(cfg_exposure) * 256)
                     - logistic_lookup(eta0);
         rows_counted++;
      end
      closes = row.last;
      res    = '0;
      if (row.last) begin
         mean     = (rows_counted == 0) ? 0 : effect_sum / longint'(rows_counted);
         res.mean = mean[MEAN_W-1:0];
         res.rows = rows_counted[ROWS_W-1:0];
         res.ovf  = rows_dropped;
         effect_sum   = 0;
         rows_counted = 0;
         rows_dropped = 1'b0;
      end
   endfunction

   // compare one result beat with the oldest owed mean
   function automatic void check_mean_beat();
      mean_result_type want;
      if (awaited_means.size() == 0) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("unexpected result beat: mean %0d rows %0d overflow %0d",
                     rsp_mean_effect, rsp_rows_used, rsp_row_overflow);
      end else begin
         want = awaited_means.pop_front();
         if (rsp_mean_effect !== want.mean || rsp_rows_used !== want.rows ||
             rsp_row_overflow !== want.ovf) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("mismatch: mean exp %0d got %0d, rows exp %0d got %0d, %s%0d got %0d",
                        $signed(want.mean), rsp_mean_effect, want.rows, rsp_rows_used,
                        "overflow exp ", want.ovf, rsp_row_overflow);
         end
      end
   endfunction

   // result side: check beats, stall at random, honor a long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_mean_beat();
      if (hold_off_req) begin
         hold_off_left = HOLD_OFF_CYCLES;
         hold_off_req  = 1'b0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // mostly small signed values, with extremes and full-range words mixed in
   function automatic logic [DATA_W-1:0] pick_word(int span);
      int v;
      case ($urandom_range(19))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return DATA_W'($urandom);
         3: return $urandom_range(1) ? 16'hFFFF : 16'h0001;
         default: begin
            v = int'($urandom_range(2 * span)) - span;
            return v[DATA_W-1:0];
         end
      endcase
   endfunction

   function automatic row_type random_row(bit last);
      row_type r;
      for (int i = 0; i < FEATURE_COUNT; i++)
         r.feat[i] = pick_word(768);
      r.last = last;
      return r;
   endfunction

   // directed table builders
   function automatic void dir_csr(logic [CSR_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
      dir_entry_type e;
      e       = '{kind: DIR_CSR, default: '0};
      e.idx   = idx;
      e.data  = data;
      dir_table.push_back(e);
   endfunction

   function automatic void dir_row(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                   logic [DATA_W-1:0] c, logic [DATA_W-1:0] d,
                                   logic last);
      dir_entry_type e;
      e          = '{kind: DIR_ROW, default: '0};
      e.row.feat = {d, c, b, a};
      e.row.last = last;
      dir_table.push_back(e);
   endfunction

   // pin the result of the row just added to a value read off by hand
   function automatic void dir_expect(int mean, int rows, bit ovf);
      dir_table[$].typed    = 1'b1;
      dir_table[$].res.mean = MEAN_W'(mean);
      dir_table[$].res.rows = ROWS_W'(rows);
      dir_table[$].res.ovf  = ovf;
   endfunction

   // stop sending, wait for every owed mean, then let the divider drain
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_means.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      apply_register(idx, data);
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_config(logic [DATA_W-1:0] intercept, logic [DATA_W-1:0] exposure);
      write_reg(REG_INTERCEPT, intercept);
      write_reg(REG_EXPOSURE, exposure);
      write_reg(REG_COEF_A, pick_word(384));
      write_reg(REG_COEF_B, pick_word(384));
      write_reg(REG_COEF_C, pick_word(384));
      write_reg(REG_COEF_D, pick_word(384));
   endtask

   // offer one row, hold it until taken, then owe its mean if it ends a set
   task automatic send_row(row_type row, bit typed = 1'b0, mean_result_type pinned = '0);
      bit              closes;
      mean_result_type res;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_feature_a <= row.feat[0];
      req_feature_b <= row.feat[1];
      req_feature_c <= row.feat[2];
      req_feature_d <= row.feat[3];
      req_last_row  <= row.last;
      do @(posedge clock); while (!req_ready);
      fold_row(row, closes, res);
      if (closes)
         awaited_means.push_back(typed ? pinned : res);
   endtask

   task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   initial begin
      int  set_len;
      int  rows_sent;
      bit  mid_done;
      bit  prev_csr;

      build_logistic_lut();
      cfg_intercept = '0;
      cfg_exposure  = '0;
      foreach (cfg_coef[i])
         cfg_coef[i] = '0;
      effect_sum     = 0;
      rows_counted   = 0;
      rows_dropped   = 1'b0;
      hold_off_req   = 1'b0;
      hold_off_left  = 0;
      error_count    = 0;
      set_idling(0, 0);

      // reset config: every coefficient zero, so both probabilities match
      dir_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
      dir_expect(0, 1, 1'b0);
      dir_row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
      dir_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      dir_expect(0, 2, 1'b0);
      // both predictors far below the table: same first bin
      dir_csr(REG_INTERCEPT, 16'h8000);
      dir_csr(REG_EXPOSURE, 16'h8000);
      dir_row(16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 1'b1);
      dir_expect(0, 1, 1'b0);
      // both predictors above the clamp: exactly one on each side
      dir_csr(REG_INTERCEPT, 16'h7FFF);
      dir_csr(REG_EXPOSURE, 16'h7FFF);
      dir_row(16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 1'b1);
      dir_expect(0, 1, 1'b0);
      // exposed predictor lands just below zero
      dir_csr(REG_EXPOSURE, 16'h8000);
      dir_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      // unexposed predictor exactly at the clamp, exposed just past it
      dir_csr(REG_INTERCEPT, 16'h3200);
      dir_csr(REG_EXPOSURE, 16'h0001);
      dir_row(16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0, 1'b1);
      // table edges: offset exactly zero, just under, span end, just under it
      dir_csr(REG_INTERCEPT, 16'h0000);
      dir_csr(REG_COEF_C, 16'h0100);
      dir_row(16'h0000, 16'h0000, 16'hF800, 16'h0000, 1'b0);
      dir_row(16'h0000, 16'h0000, 16'hF7FF, 16'h0000, 1'b0);
      dir_row(16'h0000, 16'h0000, 16'h0800, 16'h0000, 1'b0);
      dir_row(16'h0000, 16'h0000, 16'h07FF, 16'h0000, 1'b1);
      // extreme coefficients against extreme features
      dir_csr(REG_COEF_A, 16'h7FFF);
      dir_csr(REG_COEF_B, 16'h8000);
      dir_csr(REG_COEF_D, 16'hFF00);
      dir_csr(REG_EXPOSURE, 16'h0100);
      dir_csr(REG_INTERCEPT, 16'hFF80);
      dir_row(16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 1'b0);
      dir_row(16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 1'b0);
      dir_row(16'h0001, 16'hFFFF, 16'h0100, 16'h0000, 1'b0);
      dir_row(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1);
      // writes to spare indexes must leave every register alone
      dir_csr(REG_SPARE_LO, 16'hA5A5);
      dir_csr(REG_SPARE_HI, 16'h5A5A);
      dir_row(16'h0100, 16'hFF00, 16'h0080, 16'hFF80, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed rows, registers only touched once the block has drained
      prev_csr = 1'b0;
      foreach (dir_table[n]) begin
         if (dir_table[n].kind == DIR_CSR) begin
            if (!prev_csr)
               wait_drained();
            write_reg(dir_table[n].idx, dir_table[n].data);
            prev_csr = 1'b1;
         end else begin
            send_row(dir_table[n].row, dir_table[n].typed, dir_table[n].res);
            prev_csr = 1'b0;
         end
      end

      // random phases: no idling, sender idle, receiver stalling, both
      for (int phase = 0; phase < 4; phase++) begin
         wait_drained();
         case (phase)
            0: set_idling(0, 0);
            1: set_idling(51, 0);
            2: set_idling(0, 51);
            default: set_idling(33, 33);
         endcase
         load_config(pick_word(1024), pick_word(768));
         rows_sent = 0;
         mid_done  = 1'b0;
         while (rows_sent < PHASE_ROWS) begin
            if (!mid_done && rows_sent >= PHASE_ROWS / 2) begin
               mid_done = 1'b1;
               // long result hold-off while rows keep coming: block backs up
               if (phase == 2)
                  hold_off_req = 1'b1;
               // sender pause until every owed mean is back
               if (phase == 1)
                  wait_drained();
            end
            set_len = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
            for (int r = 0; r < set_len; r++)
               send_row(random_row(r == set_len - 1));
            rows_sent += set_len;
         end
      end

      // short closing set with both sides idling
      for (int r = 0; r < 3; r++)
         send_row(random_row(r == 2));

      wait_drained();
      if (error_count == 0)
         $display("tb_logistic_treatment_effect_mean: PASS");
      else
         $display("tb_logistic_treatment_effect_mean: FAIL");
      $finish;
   end

endmodule
